[rtl/core/rrqmtf_pkg.sv]
// ----------------------------------------------------------------------------
// rrqmtf_pkg: shared types and codes of the service queue
// Operation and status codes, word widths and the sequencer state type.
// ----------------------------------------------------------------------------
package rrqmtf_pkg;

	localparam int ID_W = 32;
	localparam int OP_W = 2;
	localparam int ST_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_SERVE    = 2'd0,
		OP_EXPEDITE = 2'd1,
		OP_RESTART  = 2'd2,
		OP_UNUSED   = 2'd3
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_SERVED = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_FULL   = 2'd2,
		ST_RSVD   = 2'd3
	} status_t;

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_SERVE_WR = 7'b0000010,
		S_SRCH     = 7'b0000100,
		S_SHIFT    = 7'b0001000,
		S_PLACE    = 7'b0010000,
		S_FILL     = 7'b0100000,
		S_EMIT     = 7'b1000000
	} seq_state_t;

endpackage

[rtl/core/rrqmtf_ram.sv]
// ----------------------------------------------------------------------------
// rrqmtf_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module rrqmtf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/core/round_robin_queue_move_to_front_unit.sv]
// ----------------------------------------------------------------------------
// round_robin_queue_move_to_front_unit: ordered service queue of ids
// Serve rotates the head to the tail, expedite moves or inserts an id at the
// head, restart reloads ids 1..min(population, DEPTH).
// ----------------------------------------------------------------------------
// The queue lives in a circular buffer in one RAM with a registered read
// port and one write port; a head pointer and a length register frame it.
// One word is handled at a time and in_ready is low while it is at work.
// An expedite reads the queue from the head until it finds the id; if the
// id sits behind the head, every entry ahead of it moves back by one place
// and the id is then written at the head. An absent id is written in front
// of the head, or refused when the queue is full. Restart writes the ids
// one slot at a time. A result (serve, or a refused expedite) lands in an
// output register and waits there for out_ready; the next word is accepted
// as soon as the result has been handed to that register.
// Operation code 3 is dropped with no result. No clearing pass is needed:
// only entries inside the framed region are ever used.
// ----------------------------------------------------------------------------
module round_robin_queue_move_to_front_unit
	import rrqmtf_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_wr_en,
	input  logic [ID_W-1:0] cfg_wr_data,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [OP_W-1:0] operation,
	input  logic [ID_W-1:0] target_id,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [ID_W-1:0] served_id,
	output logic [ST_W-1:0] status
);

	localparam int AW = $clog2(DEPTH);
	localparam int LW = $clog2(DEPTH + 1);

	// physical slot of logical position k, wrapped with one compare/subtract
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [LW-1:0] k);
		logic [LW:0] s;
		s = (LW+1)'(h) + (LW+1)'(k);
		if (s >= (LW+1)'(DEPTH)) begin
			s = s - (LW+1)'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	seq_state_t      state_q;
	logic [AW-1:0]   head_q;
	logic [LW-1:0]   len_q;
	logic [LW-1:0]   cnt_q;
	logic [ID_W-1:0] pop_q;
	logic [ID_W-1:0] id_q;
	logic [ID_W-1:0] res_id_q;
	status_t         res_st_q;
	logic            out_valid_q;
	logic [ID_W-1:0] served_id_q;
	logic [ST_W-1:0] status_q;

	logic [ID_W-1:0] rd_data;
	logic [LW-1:0]   rd_k;
	logic [AW-1:0]   rd_addr;
	logic            wr_en;
	logic [LW-1:0]   wr_k;
	logic [AW-1:0]   wr_addr;
	logic [ID_W-1:0] wr_data;
	logic            hit;
	logic            last;
	logic            full;
	logic [LW-1:0]   fill_n;
	logic            in_acc;
	op_t             op_in;

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign op_in     = op_t'(operation);
	assign out_valid = out_valid_q;
	assign served_id = served_id_q;
	assign status    = status_q;

	assign hit    = (rd_data == id_q);
	assign last   = ((cnt_q + LW'(1)) == len_q);
	assign full   = (len_q == LW'(DEPTH));
	assign fill_n = (pop_q >= ID_W'(DEPTH)) ? LW'(DEPTH) : pop_q[LW-1:0];

	// read and write address selection, all in logical positions from the head
	always_comb begin
		rd_k    = '0;
		wr_en   = 1'b0;
		wr_k    = '0;
		wr_data = rd_data;
		case (state_q)
			S_IDLE: begin
				rd_k = '0;
			end
			S_SERVE_WR: begin
				// old head goes just past the tail
				wr_en = 1'b1;
				wr_k  = len_q;
			end
			S_SRCH: begin
				rd_k = hit ? (cnt_q - LW'(1)) : (cnt_q + LW'(1));
				if (!hit && last && !full) begin
					// insert absent id in front of the head
					wr_en   = 1'b1;
					wr_k    = LW'(DEPTH - 1);
					wr_data = id_q;
				end
			end
			S_SHIFT: begin
				rd_k  = cnt_q - LW'(2);
				wr_en = 1'b1;
				wr_k  = cnt_q;
			end
			S_PLACE: begin
				wr_en   = 1'b1;
				wr_k    = '0;
				wr_data = id_q;
			end
			S_FILL: begin
				wr_en   = (cnt_q != fill_n);
				wr_k    = cnt_q;
				wr_data = ID_W'(cnt_q) + ID_W'(1);
			end
			default: begin
				rd_k = '0;
			end
		endcase
	end

	assign rd_addr = phys(head_q, rd_k);
	assign wr_addr = phys(head_q, wr_k);

	rrqmtf_ram #(
		.WIDTH(ID_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop_q <= '0;
		end else if (cfg_wr_en) begin
			pop_q <= cfg_wr_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			len_q    <= '0;
			cnt_q    <= '0;
			id_q     <= '0;
			res_id_q <= '0;
			res_st_q <= ST_SERVED;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						id_q  <= target_id;
						cnt_q <= '0;
						case (op_in)
							OP_SERVE: begin
								if (len_q == '0) begin
									res_id_q <= '0;
									res_st_q <= ST_EMPTY;
									state_q  <= S_EMIT;
								end else begin
									state_q <= S_SERVE_WR;
								end
							end
							OP_EXPEDITE: begin
								if (len_q == '0) begin
									// empty queue: the id simply becomes the head
									len_q   <= LW'(1);
									state_q <= S_PLACE;
								end else begin
									state_q <= S_SRCH;
								end
							end
							OP_RESTART: begin
								head_q  <= '0;
								len_q   <= '0;
								state_q <= S_FILL;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_SERVE_WR: begin
					head_q   <= phys(head_q, LW'(1));
					res_id_q <= rd_data;
					res_st_q <= ST_SERVED;
					state_q  <= S_EMIT;
				end
				S_SRCH: begin
					if (hit) begin
						if (cnt_q == '0) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_SHIFT;
						end
					end else if (last) begin
						if (full) begin
							res_id_q <= '0;
							res_st_q <= ST_FULL;
							state_q  <= S_EMIT;
						end else begin
							head_q  <= phys(head_q, LW'(DEPTH - 1));
							len_q   <= len_q + LW'(1);
							state_q <= S_IDLE;
						end
					end else begin
						cnt_q <= cnt_q + LW'(1);
					end
				end
				S_SHIFT: begin
					// move entry cnt-1 back to cnt, walk toward the head
					cnt_q <= cnt_q - LW'(1);
					if (cnt_q == LW'(1)) begin
						state_q <= S_PLACE;
					end
				end
				S_PLACE: begin
					state_q <= S_IDLE;
				end
				S_FILL: begin
					if (cnt_q == fill_n) begin
						len_q   <= fill_n;
						state_q <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + LW'(1);
					end
				end
				S_EMIT: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register: hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_EMIT && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && (!out_valid_q || out_ready)) begin
			served_id_q <= res_id_q;
			status_q    <= res_st_q;
		end
	end

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for the round-robin service queue
// Directed words cover the corners: empty serve, move of an id that is already
// queued, insertion, refusal on a full queue, restart above the queue depth and
// the unused code. Random phases then run under several population settings.
// A shadow copy of the queue predicts every result; the monitor compares each
// word that leaves the block against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
	import rrqmtf_pkg::*;

	localparam int DEPTH         = 16;
	// Longest busy stretch after a word is accepted: an expedite of the tail
	// entry walks the whole queue twice. Leave some margin on top.
	localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int PHASE_WORDS   = 118;
	localparam int LONG_HOLD     = 300;

	typedef struct {
		op_t             op;
		logic [ID_W-1:0] id;
	} queue_word_t;

	typedef struct {
		logic [ID_W-1:0] served_id;
		status_t         status;
	} service_result_t;

	logic            clk         = 1'b0;
	logic            arst_n      = 1'b0;
	logic            cfg_wr_en   = 1'b0;
	logic [ID_W-1:0] cfg_wr_data = '0;
	logic            in_valid    = 1'b0;
	logic            in_ready;
	logic [OP_W-1:0] operation   = OP_SERVE;
	logic [ID_W-1:0] target_id   = '0;
	logic            out_valid;
	logic            out_ready   = 1'b0;
	logic [ID_W-1:0] served_id;
	logic [ST_W-1:0] status;

	// Shadow of the block: queue contents head first, fill level and register.
	logic [ID_W-1:0] model_ids [DEPTH];
	int              model_len;
	logic [ID_W-1:0] model_population;

	queue_word_t     words_to_send[$];
	service_result_t awaited_results[$];
	queue_word_t     on_offer;

	int sender_gap;
	int receiver_stall;
	int words_sent;
	int results_seen;
	int mismatch_count;
	int cycle_count;

	round_robin_queue_move_to_front_unit #(
		.DEPTH(DEPTH)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.target_id  (target_id),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.served_id  (served_id),
		.status     (status)
	);

	always #5 clk = ~clk;

	// Apply one accepted word to the shadow queue and queue up the result the
	// block owes for it, if any.
	function automatic void predict_service_result(queue_word_t w);
		int              pos;
		int              fill;
		logic [ID_W-1:0] head_id;
		service_result_t r;
		case (w.op)
		OP_SERVE: begin
			if (model_len == 0) begin
				r.served_id = '0;
				r.status    = ST_EMPTY;
			end else begin
				// rotate the head to the tail
				head_id = model_ids[0];
				for (int i = 1; i < model_len; i++)
					model_ids[i-1] = model_ids[i];
				model_ids[model_len-1] = head_id;
				r.served_id = head_id;
				r.status    = ST_SERVED;
			end
			awaited_results.push_back(r);
		end
		OP_EXPEDITE: begin
			// first match from the head wins
			pos = model_len;
			for (int i = 0; i < model_len; i++) begin
				if (model_ids[i] == w.id) begin
					pos = i;
					break;
				end
			end
			if (pos == model_len && model_len >= DEPTH) begin
				r.served_id = '0;
				r.status    = ST_FULL;
				awaited_results.push_back(r);
			end else begin
				if (pos == model_len)
					model_len++;
				for (int i = pos; i > 0; i--)
					model_ids[i] = model_ids[i-1];
				model_ids[0] = w.id;
			end
		end
		OP_RESTART: begin
			fill = (model_population < DEPTH) ? int'(model_population) : DEPTH;
			for (int i = 0; i < fill; i++)
				model_ids[i] = i + 1;
			model_len = fill;
		end
		default: begin
			// unused code: drop, no state change
		end
		endcase
	endfunction

	function automatic queue_word_t draw_random_word();
		queue_word_t w;
		int unsigned pick;
		pick = $urandom_range(99, 0);
		if (pick < 40)
			w.op = OP_SERVE;
		else if (pick < 85)
			w.op = OP_EXPEDITE;
		else if (pick < 95)
			w.op = OP_RESTART;
		else
			w.op = OP_UNUSED;
		// Mostly ids near the restart range so expedites hit queued entries and
		// the queue fills up; some full-width ids and the extremes as well.
		pick = $urandom_range(99, 0);
		if (pick < 65)
			w.id = $urandom_range(24, 0);
		else if (pick < 90)
			w.id = $urandom;
		else if (pick < 95)
			w.id = '0;
		else
			w.id = '1;
		return w;
	endfunction

	task automatic send_word(input op_t op, input logic [ID_W-1:0] id);
		queue_word_t w;
		w.op = op;
		w.id = id;
		words_to_send.push_back(w);
	endtask

	// Write the population register; only called while the block is idle.
	task automatic set_population(input logic [ID_W-1:0] value);
		@(posedge clk);
		cfg_wr_en        <= 1'b1;
		cfg_wr_data      <= value;
		model_population = value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Wait until every word is accepted and every result is back, then let a
	// word with no result finish its walk through the queue.
	task automatic wait_until_idle();
		while (words_to_send.size() != 0 || in_valid || awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Driver: offer words from the pending list, hold each one until it is
	// taken, then leave a random idle gap, possibly none, before the next.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			operation  <= OP_SERVE;
			target_id  <= '0;
			sender_gap = 0;
			words_sent = 0;
		end else begin
			if (in_valid && in_ready) begin
				predict_service_result(on_offer);
				words_sent++;
				// every third stretch of words goes back to back
				if ((words_sent / 97) % 3 == 2)
					sender_gap = 0;
				else
					sender_gap = $urandom_range(3, 0);
			end
			if (in_valid && !in_ready) begin
				// hold the word on offer
			end else if (sender_gap == 0 && words_to_send.size() != 0) begin
				on_offer = words_to_send.pop_front();
				in_valid  <= 1'b1;
				operation <= on_offer.op;
				target_id <= on_offer.id;
			end else begin
				if (sender_gap > 0)
					sender_gap--;
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: check each result word, then hold out_ready low for a random
	// spell, possibly none. Twice in the run, hold off for a long stretch so the
	// output register backs up and the block stalls its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready      <= 1'b0;
			receiver_stall = 0;
			results_seen   = 0;
			mismatch_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					$error("result with nothing pending: served_id %h status %0d",
						served_id, status);
					mismatch_count++;
				end else begin
					if (served_id !== awaited_results[0].served_id) begin
						$error("served_id: expected %h, actual %h",
							awaited_results[0].served_id, served_id);
						mismatch_count++;
					end
					if (status !== awaited_results[0].status) begin
						$error("status: expected %0d, actual %0d",
							awaited_results[0].status, status);
						mismatch_count++;
					end
					void'(awaited_results.pop_front());
				end
				results_seen++;
				if (results_seen == 150 || results_seen == 300)
					receiver_stall = LONG_HOLD;
				else if ((results_seen / 61) % 3 == 1)
					receiver_stall = 0;
				else
					receiver_stall = $urandom_range(3, 0);
			end else if (receiver_stall > 0) begin
				receiver_stall--;
			end
			out_ready <= (receiver_stall == 0);
		end
	end

	// Watchdog: end the run if it hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		logic [ID_W-1:0] phase_pops [8];
		model_len        = 0;
		model_population = '0;
		cycle_count      = 0;
		phase_pops = '{32'd0, 32'd1, 32'd2, 32'd15, 32'd16, 32'd17, $urandom, '1};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty queue corners: serve on empty, restart that loads nothing,
		// insertion of the extreme ids, move of a queued id, unused code.
		set_population('0);
		send_word(OP_SERVE, '0);
		send_word(OP_RESTART, '1);
		send_word(OP_SERVE, '1);
		send_word(OP_EXPEDITE, '1);
		send_word(OP_EXPEDITE, '0);
		send_word(OP_EXPEDITE, '1);
		send_word(OP_SERVE, '0);
		send_word(OP_SERVE, '0);
		send_word(OP_UNUSED, 32'd5);
		send_word(OP_SERVE, '0);
		send_word(OP_EXPEDITE, '0);
		wait_until_idle();

		// Full queue corners: restart clipped to the depth, refusal of an
		// absent id, moves of the tail and the second entry, unused code when full.
		set_population('1);
		send_word(OP_RESTART, '0);
		send_word(OP_EXPEDITE, 32'hDEAD_BEEF);
		send_word(OP_EXPEDITE, DEPTH);
		send_word(OP_EXPEDITE, 32'd1);
		send_word(OP_SERVE, '0);
		send_word(OP_SERVE, '0);
		send_word(OP_EXPEDITE, '0);
		send_word(OP_UNUSED, '1);
		send_word(OP_SERVE, '0);
		send_word(OP_RESTART, 32'd3);
		send_word(OP_SERVE, '0);
		wait_until_idle();

		// Random phases, one per population setting; start each from a
		// freshly loaded queue.
		for (int p = 0; p < 8; p++) begin
			set_population(phase_pops[p]);
			send_word(OP_RESTART, $urandom);
			for (int n = 1; n < PHASE_WORDS; n++)
				words_to_send.push_back(draw_random_word());
			wait_until_idle();
		end

		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
